// ===== design/tdac_pkg.sv =====
// Types and constants shared by the tilt deadband actuator control block.
`default_nettype none

package tdac_pkg;

	localparam int ACCEL_W         = 16;
	localparam int PITCH_W         = 8;
	localparam int DEADBAND_W      = 7;
	localparam int CFG_INDEX_W     = 2;
	localparam int CFG_DATA_W      = 8;

	// Squared-magnitude sum scaled by 2^16 and its integer square root.
	localparam int SUM_W           = 32;
	localparam int SQRT_IN_W       = SUM_W + 16;
	localparam int SQRT_STAGES     = SQRT_IN_W / 2;
	localparam int ROOT_W          = SQRT_STAGES;

	// CORDIC datapath widths: vector coordinates and Q16 angle in degrees.
	localparam int X8_W            = ACCEL_W + 8;
	localparam int XY_W            = 27;
	localparam int ANG_W           = 25;
	localparam int ANGLE_FRAC      = 16;
	localparam int ANGLE_TABLE_LEN = 24;
	localparam int WHOLE_W         = ANG_W - ANGLE_FRAC;
	localparam int CMP_W           = 10;

	localparam logic [WHOLE_W-1:0] PITCH_LIMIT = WHOLE_W'(90);
	localparam logic signed [PITCH_W-1:0] PITCH_POS_LIMIT = PITCH_W'(90);
	localparam logic signed [PITCH_W-1:0] PITCH_NEG_LIMIT = -PITCH_W'(90);

	localparam logic signed [PITCH_W-1:0]  TARGET_PITCH_RESET = '0;
	localparam logic [DEADBAND_W-1:0]      DEADBAND_RESET     = DEADBAND_W'(3);

	localparam logic [CFG_INDEX_W-1:0] REG_TARGET_PITCH = CFG_INDEX_W'(0);
	localparam logic [CFG_INDEX_W-1:0] REG_DEADBAND     = CFG_INDEX_W'(1);

	// atan(2^-i) in degrees, unsigned Q16, rounded to nearest.
	localparam logic [22:0] ATAN_DEG_Q16 [ANGLE_TABLE_LEN] = '{
		23'd2949120, 23'd1740967, 23'd919879, 23'd466945,
		23'd234379,  23'd117304,  23'd58666,  23'd29335,
		23'd14668,   23'd7334,    23'd3667,   23'd1833,
		23'd917,     23'd458,     23'd229,    23'd115,
		23'd57,      23'd29,      23'd14,     23'd7,
		23'd4,       23'd2,       23'd1,      23'd0
	};

	typedef enum logic [1:0] {
		DRIVE_STOP    = 2'd0,
		DRIVE_EXTEND  = 2'd1,
		DRIVE_RETRACT = 2'd2
	} drive_cmd_t;

	typedef struct packed {
		logic signed [ACCEL_W-1:0] accel_x;
		logic signed [ACCEL_W-1:0] accel_y;
		logic signed [ACCEL_W-1:0] accel_z;
	} accel_sample_t;

	typedef struct packed {
		logic signed [PITCH_W-1:0] pitch_degrees;
		drive_cmd_t                drive_command;
	} pitch_result_t;

	// Side information that bypasses the CORDIC when y and z are both zero.
	typedef struct packed {
		logic mag_zero;
		logic x_neg;
		logic x_zero;
	} tilt_flags_t;

endpackage

`default_nettype wire

// ===== design/tilt_deadband_actuator_control.sv =====
// Pitch from an accelerometer sample by pipelined square root and CORDIC, with deadband control.
// Pipeline stages from the accepting edge to the done cycle:
// (2 stages for squares and sum, 24 square-root stages, one stage per CORDIC step, 2 output stages).
// Throughput: one transaction per cycle; busy is always low and the receiver cannot stall.
// Reset clears all valid bits and sets target_pitch to 0 and deadband to 3.
`default_nettype none

module tilt_deadband_actuator_control
	import tdac_pkg::*;
#(
	parameter int CORDIC_STEPS = 16
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   start,
	output logic                        busy,
	input  wire accel_sample_t          sample,
	output logic                        done,
	output pitch_result_t               result,
	input  wire logic                   cfg_we,
	input  wire logic [CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

	localparam int LAST_SQ = SQRT_STAGES - 1;
	localparam int LAST_CD = CORDIC_STEPS - 1;

	logic signed [PITCH_W-1:0] target_pitch_q;
	logic [DEADBAND_W-1:0]     deadband_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_pitch_q <= TARGET_PITCH_RESET;
			deadband_q     <= DEADBAND_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_TARGET_PITCH: target_pitch_q <= cfg_data[PITCH_W-1:0];
				REG_DEADBAND:     deadband_q     <= cfg_data[DEADBAND_W-1:0];
				default:          ;
			endcase
		end
	end

	assign busy = 1'b0;

	// Stage 1: squares of y and z.
	logic                      valid_s1;
	logic signed [ACCEL_W-1:0] x_s1;
	logic [SUM_W-2:0]          ysq_s1, zsq_s1;
	logic signed [SUM_W-1:0]   ysq_full, zsq_full;

	assign ysq_full = SUM_W'(sample.accel_y) * SUM_W'(sample.accel_y);
	assign zsq_full = SUM_W'(sample.accel_z) * SUM_W'(sample.accel_z);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		x_s1   <= sample.accel_x;
		ysq_s1 <= ysq_full[SUM_W-2:0];
		zsq_s1 <= zsq_full[SUM_W-2:0];
	end

	// Stage 2: sum of squares, scaled for the root, x at the root's scale, and the flags.
	logic                    valid_s2;
	logic [SQRT_IN_W-1:0]    n_s2;
	logic signed [X8_W-1:0]  x8_s2;
	tilt_flags_t             flags_s2;
	logic [SUM_W-1:0]        sum_s1;

	assign sum_s1 = {1'b0, ysq_s1} + {1'b0, zsq_s1};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		n_s2              <= {sum_s1, 16'b0};
		x8_s2             <= {x_s1, 8'b0};
		flags_s2.mag_zero <= (sum_s1 == '0);
		flags_s2.x_neg    <= x_s1[ACCEL_W-1];
		flags_s2.x_zero   <= (x_s1 == '0);
	end

	// Square root, one result bit per stage.
	logic [SQRT_STAGES-1:0] sq_valid_s;
	logic [SQRT_IN_W-1:0]   sq_rem_s   [SQRT_STAGES];
	logic [SQRT_IN_W-1:0]   sq_root_s  [SQRT_STAGES];
	logic signed [X8_W-1:0] sq_x8_s    [SQRT_STAGES];
	tilt_flags_t            sq_flags_s [SQRT_STAGES];

	logic [SQRT_IN_W-1:0]   sq_rem_in  [SQRT_STAGES];
	logic [SQRT_IN_W-1:0]   sq_root_in [SQRT_STAGES];
	logic [SQRT_IN_W-1:0]   sq_rem_nx  [SQRT_STAGES];
	logic [SQRT_IN_W-1:0]   sq_root_nx [SQRT_STAGES];

	always_comb begin
		logic [SQRT_IN_W-1:0] one_v;
		logic [SQRT_IN_W:0]   trial_v;
		sq_rem_in[0]  = n_s2;
		sq_root_in[0] = '0;
		for (int k = 1; k < SQRT_STAGES; k++) begin
			sq_rem_in[k]  = sq_rem_s[k-1];
			sq_root_in[k] = sq_root_s[k-1];
		end
		for (int k = 0; k < SQRT_STAGES; k++) begin
			one_v   = SQRT_IN_W'(1) << (2 * (SQRT_STAGES - 1 - k));
			trial_v = {1'b0, sq_root_in[k]} + {1'b0, one_v};
			if ({1'b0, sq_rem_in[k]} >= trial_v) begin
				sq_rem_nx[k]  = sq_rem_in[k] - trial_v[SQRT_IN_W-1:0];
				sq_root_nx[k] = (sq_root_in[k] >> 1) + one_v;
			end else begin
				sq_rem_nx[k]  = sq_rem_in[k];
				sq_root_nx[k] = sq_root_in[k] >> 1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sq_valid_s <= '0;
		end else begin
			sq_valid_s <= {sq_valid_s[SQRT_STAGES-2:0], valid_s2};
		end
	end

	always_ff @(posedge clk) begin
		sq_x8_s[0]    <= x8_s2;
		sq_flags_s[0] <= flags_s2;
		for (int k = 1; k < SQRT_STAGES; k++) begin
			sq_x8_s[k]    <= sq_x8_s[k-1];
			sq_flags_s[k] <= sq_flags_s[k-1];
		end
		for (int k = 0; k < SQRT_STAGES; k++) begin
			sq_rem_s[k]  <= sq_rem_nx[k];
			sq_root_s[k] <= sq_root_nx[k];
		end
	end

	// CORDIC in vectoring mode, one micro-rotation per stage.
	logic [CORDIC_STEPS-1:0] cd_valid_s;
	logic signed [XY_W-1:0]  cd_x_s     [CORDIC_STEPS];
	logic signed [XY_W-1:0]  cd_y_s     [CORDIC_STEPS];
	logic signed [ANG_W-1:0] cd_a_s     [CORDIC_STEPS];
	tilt_flags_t             cd_flags_s [CORDIC_STEPS];

	logic signed [XY_W-1:0]  cd_x_in  [CORDIC_STEPS];
	logic signed [XY_W-1:0]  cd_y_in  [CORDIC_STEPS];
	logic signed [ANG_W-1:0] cd_a_in  [CORDIC_STEPS];
	logic signed [XY_W-1:0]  cd_x_nx  [CORDIC_STEPS];
	logic signed [XY_W-1:0]  cd_y_nx  [CORDIC_STEPS];
	logic signed [ANG_W-1:0] cd_a_nx  [CORDIC_STEPS];

	always_comb begin
		logic signed [ANG_W-1:0] ang_v;
		cd_x_in[0] = $signed(XY_W'(sq_root_s[LAST_SQ][ROOT_W-1:0]));
		cd_y_in[0] = XY_W'(sq_x8_s[LAST_SQ]);
		cd_a_in[0] = '0;
		for (int i = 1; i < CORDIC_STEPS; i++) begin
			cd_x_in[i] = cd_x_s[i-1];
			cd_y_in[i] = cd_y_s[i-1];
			cd_a_in[i] = cd_a_s[i-1];
		end
		for (int i = 0; i < CORDIC_STEPS; i++) begin
			ang_v = $signed(ANG_W'(ATAN_DEG_Q16[i]));
			if (!cd_y_in[i][XY_W-1] && (cd_y_in[i] != '0)) begin
				cd_x_nx[i] = cd_x_in[i] + (cd_y_in[i] >>> i);
				cd_y_nx[i] = cd_y_in[i] - (cd_x_in[i] >>> i);
				cd_a_nx[i] = cd_a_in[i] + ang_v;
			end else begin
				cd_x_nx[i] = cd_x_in[i] - (cd_y_in[i] >>> i);
				cd_y_nx[i] = cd_y_in[i] + (cd_x_in[i] >>> i);
				cd_a_nx[i] = cd_a_in[i] - ang_v;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cd_valid_s <= '0;
		end else begin
			cd_valid_s <= {cd_valid_s[CORDIC_STEPS-2:0], sq_valid_s[LAST_SQ]};
		end
	end

	always_ff @(posedge clk) begin
		cd_flags_s[0] <= sq_flags_s[LAST_SQ];
		for (int i = 1; i < CORDIC_STEPS; i++) begin
			cd_flags_s[i] <= cd_flags_s[i-1];
		end
		for (int i = 0; i < CORDIC_STEPS; i++) begin
			cd_x_s[i] <= cd_x_nx[i];
			cd_y_s[i] <= cd_y_nx[i];
			cd_a_s[i] <= cd_a_nx[i];
		end
	end

	// Final stage: negate the angle, truncate toward zero, saturate, and apply
	// the exact answers for a sample with no y or z component.
	logic                      valid_sf;
	logic signed [PITCH_W-1:0] pitch_sf;
	logic signed [PITCH_W-1:0] pitch_nx;

	always_comb begin
		logic signed [ANG_W-1:0] p_v;
		logic [ANG_W-1:0]        mag_v;
		logic [WHOLE_W-1:0]      whole_v;
		logic [PITCH_W-1:0]      sat_v;
		tilt_flags_t             fl_v;
		fl_v    = cd_flags_s[LAST_CD];
		p_v     = -cd_a_s[LAST_CD];
		mag_v   = p_v[ANG_W-1] ? -p_v : p_v;
		whole_v = mag_v[ANG_W-1:ANGLE_FRAC];
		sat_v   = (whole_v > PITCH_LIMIT) ? PITCH_W'(PITCH_LIMIT) : whole_v[PITCH_W-1:0];
		pitch_nx = p_v[ANG_W-1] ? -$signed(sat_v) : $signed(sat_v);
		if (fl_v.mag_zero) begin
			if (fl_v.x_zero) begin
				pitch_nx = '0;
			end else if (fl_v.x_neg) begin
				pitch_nx = PITCH_POS_LIMIT;
			end else begin
				pitch_nx = PITCH_NEG_LIMIT;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_sf <= 1'b0;
		end else begin
			valid_sf <= cd_valid_s[LAST_CD];
		end
	end

	always_ff @(posedge clk) begin
		pitch_sf <= pitch_nx;
	end

	// Output stage: compare against the band, edges inclusive.
	logic                    done_q;
	pitch_result_t           result_q;
	logic signed [CMP_W-1:0] band_lo, band_hi, pitch_w;
	drive_cmd_t              drive_nx;

	always_comb begin
		pitch_w = CMP_W'(pitch_sf);
		band_lo = CMP_W'(target_pitch_q) - $signed({3'b000, deadband_q});
		band_hi = CMP_W'(target_pitch_q) + $signed({3'b000, deadband_q});
		if (pitch_w < band_lo) begin
			drive_nx = DRIVE_EXTEND;
		end else if (pitch_w > band_hi) begin
			drive_nx = DRIVE_RETRACT;
		end else begin
			drive_nx = DRIVE_STOP;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= valid_sf;
		end
	end

	always_ff @(posedge clk) begin
		result_q.pitch_degrees <= pitch_sf;
		result_q.drive_command <= drive_nx;
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
// Self-checking testbench for the tilt deadband actuator control block.
module tb_top
	import tdac_pkg::*;
();

	localparam int STEPS        = 16;
	localparam int LATENCY      = STEPS + 28;
	localparam int STALL_LIMIT  = 1000;
	localparam int RANDOM_ITEMS = 2000;
	localparam int PHASES       = 8;

	// Indexes past the register list; writes to them must be ignored.
	localparam logic [CFG_INDEX_W-1:0] REG_SPARE_2 = CFG_INDEX_W'(2);
	localparam logic [CFG_INDEX_W-1:0] REG_SPARE_3 = CFG_INDEX_W'(3);

	typedef struct packed {
		accel_sample_t sample;
		pitch_result_t want;
	} pitch_expect_t;

	logic                   clk;
	logic                   arst_n    = 1'b0;
	logic                   start     = 1'b0;
	logic                   busy;
	accel_sample_t          sample    = '0;
	logic                   done;
	pitch_result_t          result;
	logic                   cfg_we    = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_data  = '0;

	logic signed [PITCH_W-1:0] model_target   = 8'sd0;
	logic [DEADBAND_W-1:0]     model_deadband = 7'd3;

	pitch_expect_t pending_pitch[$];
	bit sender_idles = 1'b1;
	int samples_sent;
	int results_checked;
	int reg_writes;
	int mismatches;
	int stall_cycles;

	tilt_deadband_actuator_control #(.CORDIC_STEPS(STEPS)) u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.sample    (sample),
		.done      (done),
		.result    (result),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// atan(2^-i) in degrees, Q16, rounded to nearest.
	function automatic longint atan_q16(input int i);
		case (i)
			0:  return 2949120;
			1:  return 1740967;
			2:  return 919879;
			3:  return 466945;
			4:  return 234379;
			5:  return 117304;
			6:  return 58666;
			7:  return 29335;
			8:  return 14668;
			9:  return 7334;
			10: return 3667;
			11: return 1833;
			12: return 917;
			13: return 458;
			14: return 229;
			15: return 115;
			16: return 57;
			17: return 29;
			18: return 14;
			19: return 7;
			20: return 4;
			21: return 2;
			22: return 1;
			default: return 0;
		endcase
	endfunction

	function automatic longint unsigned floor_sqrt(input longint unsigned n);
		longint unsigned root = 0;
		longint unsigned probe = 64'd1 << 62;
		while (probe > n)
			probe >>= 2;
		while (probe != 0) begin
			if (n >= root + probe) begin
				n -= root + probe;
				root = (root >> 1) + probe;
			end else begin
				root >>= 1;
			end
			probe >>= 2;
		end
		return root;
	endfunction

	function automatic logic signed [PITCH_W-1:0] tilt_pitch(input accel_sample_t s);
		longint ax = s.accel_x;
		longint ay = s.accel_y;
		longint az = s.accel_z;
		longint unsigned mag2;
		longint vx;
		longint vy;
		longint vx_old;
		longint angle = 0;
		longint whole;
		mag2 = ay * ay + az * az;
		if (mag2 == 0) begin
			if (ax > 0)
				return -8'sd90;
			if (ax < 0)
				return 8'sd90;
			return 8'sd0;
		end
		// Both coordinates carry 8 fractional bits.
		vx = longint'(floor_sqrt(mag2 << 16));
		vy = ax * 256;
		for (int i = 0; i < STEPS && i < ANGLE_TABLE_LEN; i++) begin
			vx_old = vx;
			if (vy > 0) begin
				vx += vy >>> i;
				vy -= vx_old >>> i;
				angle += atan_q16(i);
			end else begin
				vx -= vy >>> i;
				vy += vx_old >>> i;
				angle -= atan_q16(i);
			end
		end
		// The pitch is the negated angle, truncated toward zero to whole degrees.
		whole = (angle <= 0) ? ((-angle) >>> 16) : -(angle >>> 16);
		if (whole > 90)
			whole = 90;
		if (whole < -90)
			whole = -90;
		return PITCH_W'(whole);
	endfunction

	function automatic logic signed [ACCEL_W-1:0] random_axis();
		case ($urandom_range(9))
			0: return ACCEL_W'(int'($urandom_range(0, 8)) - 4);
			1: return $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
			default: return ACCEL_W'($urandom);
		endcase
	endfunction

	function automatic accel_sample_t random_sample();
		accel_sample_t s;
		s.accel_x = random_axis();
		s.accel_y = random_axis();
		s.accel_z = random_axis();
		case ($urandom_range(9))
			0: begin
				s.accel_y = '0;
				s.accel_z = '0;
			end
			1: begin
				// Nearly vertical: large x against a tiny horizontal magnitude.
				s.accel_x = ACCEL_W'($urandom);
				s.accel_y = ACCEL_W'(int'($urandom_range(0, 6)) - 3);
				s.accel_z = ACCEL_W'(int'($urandom_range(0, 2)) - 1);
			end
			default: ;
		endcase
		return s;
	endfunction

	// Prediction is made at the accepting edge with the register values in force then.
	always @(posedge clk) begin : accept_monitor
		pitch_expect_t fresh;
		int pv;
		int lo;
		int hi;
		if (!arst_n) begin
			model_target   = 8'sd0;
			model_deadband = 7'd3;
		end else begin
			if (start && !busy) begin
				fresh.sample = sample;
				fresh.want.pitch_degrees = tilt_pitch(sample);
				pv = fresh.want.pitch_degrees;
				lo = int'(model_target) - int'(model_deadband);
				hi = int'(model_target) + int'(model_deadband);
				if (pv < lo)
					fresh.want.drive_command = DRIVE_EXTEND;
				else if (pv > hi)
					fresh.want.drive_command = DRIVE_RETRACT;
				else
					fresh.want.drive_command = DRIVE_STOP;
				pending_pitch.push_back(fresh);
			end
			if (cfg_we) begin
				case (cfg_index)
					REG_TARGET_PITCH: model_target = cfg_data;
					REG_DEADBAND:     model_deadband = cfg_data[DEADBAND_W-1:0];
					default: ;
				endcase
			end
		end
	end

	always @(posedge clk) begin : result_check
		pitch_expect_t oldest;
		if (arst_n) begin
			if (done) begin
				results_checked++;
				if (pending_pitch.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result: pitch %0d drive %0d",
							result.pitch_degrees, result.drive_command);
				end else begin
					oldest = pending_pitch.pop_front();
					if (result.pitch_degrees !== oldest.want.pitch_degrees ||
							result.drive_command !== oldest.want.drive_command) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch x=%0d y=%0d z=%0d: want %0d/%0d got %0d/%0d",
								oldest.sample.accel_x, oldest.sample.accel_y,
								oldest.sample.accel_z, oldest.want.pitch_degrees,
								oldest.want.drive_command, result.pitch_degrees,
								result.drive_command);
					end
				end
			end
			if (done || (start && !busy))
				stall_cycles = 0;
			else
				stall_cycles++;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("timeout: no transaction for %0d cycles", STALL_LIMIT);
				$display("tb_top: errors");
				$finish;
			end
		end
	end

	task automatic send_sample(input accel_sample_t s);
		while (sender_idles && $urandom_range(99) < 28) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start  <= 1'b1;
		sample <= s;
		do
			@(posedge clk);
		while (busy);
		samples_sent++;
	endtask

	task automatic send_xyz(input int x, input int y, input int z);
		accel_sample_t s;
		s.accel_x = ACCEL_W'(x);
		s.accel_y = ACCEL_W'(y);
		s.accel_z = ACCEL_W'(z);
		send_sample(s);
	endtask

	task automatic drain();
		start <= 1'b0;
		// The last transaction is queued at its accepting edge, so let that edge pass first.
		@(posedge clk);
		while (pending_pitch.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input int val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= CFG_DATA_W'(val);
		@(posedge clk);
		reg_writes++;
	endtask

	task automatic set_band(input int target, input int band);
		drain();
		write_reg(REG_TARGET_PITCH, target);
		write_reg(REG_DEADBAND, band);
		cfg_we <= 1'b0;
	endtask

	// Reset configuration: target 0, deadband 3.
	task automatic test_axis_extremes();
		send_xyz(0, 0, 0);
		send_xyz(0, 0, 16384);
		send_xyz(-32768, -32768, -32768);
		send_xyz(32767, 32767, 32767);
		send_xyz(-32768, 0, 32767);
		send_xyz(32767, -32768, 0);
		send_xyz(1, -32768, -32768);
		send_xyz(1000, 0, 1000);
		send_xyz(-1000, 1000, 0);
		send_xyz(-32768, 1, 0);
		send_xyz(32767, 0, -1);
		send_xyz(5, 3, 4);
	endtask

	// With no horizontal component the pitch is exactly +90 or -90, or 0 when x is zero too.
	task automatic test_vertical_bypass();
		set_band(90, 0);
		send_xyz(-1, 0, 0);
		send_xyz(32767, 0, 0);
		send_xyz(0, 0, 0);
		set_band(-90, 0);
		send_xyz(1, 0, 0);
		send_xyz(-32768, 0, 0);
	endtask

	task automatic test_register_range();
		// Deadband data above seven bits keeps only the low seven.
		set_band(-128, 255);
		send_xyz(1000, 0, 1000);
		set_band(127, 0);
		send_xyz(0, 0, 0);
		drain();
		write_reg(REG_SPARE_2, 0);
		write_reg(REG_SPARE_3, 128);
		cfg_we <= 1'b0;
		send_xyz(0, 0, 0);
	endtask

	// Place the band so that the pitch lands exactly on its lower or upper edge.
	task automatic test_band_edges();
		accel_sample_t s;
		int p;
		int band;
		for (int k = 0; k < 6; k++) begin
			s = random_sample();
			p = tilt_pitch(s);
			band = $urandom_range(0, 12);
			set_band((k % 2) ? p + band : p - band, band);
			send_sample(s);
		end
	endtask

	task automatic test_random_stream();
		int target;
		int band;
		for (int phase = 0; phase < PHASES; phase++) begin
			target = ($urandom_range(3) == 0) ? int'($urandom_range(0, 255))
				: int'($urandom_range(0, 180)) - 90;
			band = ($urandom_range(3) == 0) ? int'($urandom_range(0, 255))
				: int'($urandom_range(0, 15));
			set_band(target, band);
			// One phase streams back to back with no gaps.
			sender_idles = (phase != 3);
			repeat (RANDOM_ITEMS / PHASES)
				send_sample(random_sample());
		end
		sender_idles = 1'b1;
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_axis_extremes();
		test_vertical_bypass();
		test_register_range();
		test_band_edges();
		test_random_stream();
		drain();
		repeat (LATENCY + 8) @(posedge clk);
		if (pending_pitch.size() != 0) begin
			$display("%0d expected results never arrived", pending_pitch.size());
			mismatches += pending_pitch.size();
		end
		$display("Sent %0d samples: axis extremes, vertical bypass, band edges, random.",
			samples_sent);
		$display("Checked %0d pitch results over %0d register writes; %0d failures.",
			results_checked, reg_writes, mismatches);
		if (mismatches == 0)
			$display("tb_top: clean");
		else
			$display("tb_top: errors");
		$finish;
	end

endmodule
